// ===== rtl/ebrld_pkg.sv =====
`timescale 1ns / 1ps

package ebrld_pkg;

    localparam int LANES       = 8;
    localparam int LANE_FIELDS = 8;
    localparam int LANE_CNT    = (LANES < 1) ? 1 : ((LANES > LANE_FIELDS) ? LANE_FIELDS : LANES);
    localparam int TOTAL_WIDTH = 24;
    localparam int OUT_TOTAL_W = 24;
    localparam int REMAIN_W    = 9;
    localparam int COUNT_W     = 4;

    localparam logic [7:0] ESC_BYTE    = 8'hFF;
    localparam logic [7:0] SHORT_LIMIT = 8'd3;

    typedef enum logic [1:0] {
        PH_LIT   = 2'd0,
        PH_COUNT = 2'd1,
        PH_RUN   = 2'd2
    } t_phase;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        logic                   last;
        logic [REMAIN_W-1:0]    remain;
        logic [TOTAL_WIDTH-1:0] total;
    } t_chunk;

endpackage

// ===== rtl/ebrld_if.sv =====
`timescale 1ns / 1ps

interface ebrld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_block;

    modport source (output valid, data_byte, end_of_block, input ready);
    modport sink   (input valid, data_byte, end_of_block, output ready);
endinterface

interface ebrld_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  lane0;
    logic [7:0]  lane1;
    logic [7:0]  lane2;
    logic [7:0]  lane3;
    logic [7:0]  lane4;
    logic [7:0]  lane5;
    logic [7:0]  lane6;
    logic [7:0]  lane7;
    logic [3:0]  valid_count;
    logic        last_of_input;
    logic [23:0] total_length;
    logic        truncated;

    modport source (output valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
                    valid_count, last_of_input, total_length, truncated, input ready);
    modport sink   (input valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
                    valid_count, last_of_input, total_length, truncated, output ready);
endinterface

// ===== rtl/ebrld_chunk_unit.sv =====
`timescale 1ns / 1ps

module ebrld_chunk_unit
    import ebrld_pkg::*;
(
    input  logic [REMAIN_W-1:0]    i_remain,
    input  logic [TOTAL_WIDTH-1:0] i_total,
    output t_chunk                 o_chunk
);

    localparam int SUM_W = TOTAL_WIDTH + 1;

    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;

    always_comb begin
        if (i_remain > REMAIN_W'(LANE_CNT)) begin
            count = COUNT_W'(LANE_CNT);
        end else begin
            count = COUNT_W'(i_remain);
        end
        sum = {1'b0, i_total} + SUM_W'(count);

        o_chunk.count  = count;
        o_chunk.last   = (i_remain <= REMAIN_W'(LANE_CNT));
        o_chunk.remain = i_remain - REMAIN_W'(count);
        o_chunk.total  = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
    end

endmodule

// ===== rtl/escape_byte_run_length_decoder.sv =====
`timescale 1ns / 1ps
// An accepted input word is registered; each output word is then registered from S_EMIT
// once the output slot is free: max(1, ceil(n/8)) words per input word, n the decoded
// bytes, packed by the single chunk unit at 8 lanes per cycle while the slot is free
// and input is held off. The next input is taken while the last result waits in its register.
// Reset: synchronous, active low; clears the sequencer, escape phase, run count, total and output valid.

module escape_byte_run_length_decoder
    import ebrld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ebrld_in_if.sink    i_in,
    ebrld_out_if.source o_out
);

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    t_phase                 ph_next;
    logic [7:0]             r_run, n_run;
    logic [REMAIN_W-1:0]    r_remain, n_remain;
    logic [7:0]             r_value, n_value;
    logic                   r_eob, n_eob;
    logic                   r_trunc, n_trunc;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;

    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_lane [LANE_FIELDS];
    logic [7:0]             n_lane [LANE_FIELDS];
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_last, n_last;
    logic [OUT_TOTAL_W-1:0] r_out_total, n_out_total;
    logic                   r_out_trunc, n_out_trunc;

    logic   in_acc;
    logic   slot_free;
    t_chunk chunk;

    ebrld_chunk_unit u_chunk (
        .i_remain (r_remain),
        .i_total  (r_total),
        .o_chunk  (chunk)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        ph_next     = r_phase;
        n_run       = r_run;
        n_remain    = r_remain;
        n_value     = r_value;
        n_eob       = r_eob;
        n_trunc     = r_trunc;
        n_total     = r_total;
        n_out_valid = r_out_valid && !o_out.ready;
        n_lane      = r_lane;
        n_count     = r_count;
        n_last      = r_last;
        n_out_total = r_out_total;
        n_out_trunc = r_out_trunc;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_eob    = i_in.end_of_block;
                    n_remain = '0;
                    case (r_phase)
                        PH_COUNT: begin
                            if (i_in.data_byte < SHORT_LIMIT) begin
                                n_remain = REMAIN_W'(i_in.data_byte) + REMAIN_W'(1);
                                n_value  = ESC_BYTE;
                                ph_next  = PH_LIT;
                            end else begin
                                n_run   = i_in.data_byte;
                                ph_next = PH_RUN;
                            end
                        end
                        PH_RUN: begin
                            n_remain = REMAIN_W'(r_run) + REMAIN_W'(1);
                            n_value  = i_in.data_byte;
                            n_run    = '0;
                            ph_next  = PH_LIT;
                        end
                        default: begin
                            if (i_in.data_byte == ESC_BYTE) begin
                                ph_next = PH_COUNT;
                            end else begin
                                n_remain = REMAIN_W'(1);
                                n_value  = i_in.data_byte;
                                ph_next  = PH_LIT;
                            end
                        end
                    endcase
                    n_trunc = i_in.end_of_block && (ph_next != PH_LIT);
                    if (i_in.end_of_block) begin
                        n_phase = PH_LIT;
                        n_run   = '0;
                    end else begin
                        n_phase = ph_next;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_count     = chunk.count;
                    for (int j = 0; j < LANE_FIELDS; j++) begin
                        n_lane[j] = (COUNT_W'(j) < chunk.count) ? r_value : 8'd0;
                    end
                    n_last      = chunk.last;
                    n_out_trunc = chunk.last && r_trunc;
                    n_out_total = OUT_TOTAL_W'(chunk.total);
                    n_remain    = chunk.remain;
                    n_total     = chunk.total;
                    if (chunk.last) begin
                        n_state = S_IDLE;
                        if (r_eob) begin
                            n_total = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LIT;
            r_run       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain    <= n_remain;
        r_value     <= n_value;
        r_eob       <= n_eob;
        r_trunc     <= n_trunc;
        r_lane      <= n_lane;
        r_count     <= n_count;
        r_last      <= n_last;
        r_out_total <= n_out_total;
        r_out_trunc <= n_out_trunc;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.lane0         = r_lane[0];
    assign o_out.lane1         = r_lane[1];
    assign o_out.lane2         = r_lane[2];
    assign o_out.lane3         = r_lane[3];
    assign o_out.lane4         = r_lane[4];
    assign o_out.lane5         = r_lane[5];
    assign o_out.lane6         = r_lane[6];
    assign o_out.lane7         = r_lane[7];
    assign o_out.valid_count   = r_count;
    assign o_out.last_of_input = r_last;
    assign o_out.total_length  = r_out_total;
    assign o_out.truncated     = r_out_trunc;

endmodule

// ===== rtl/ebrld_chk.sv =====
`timescale 1ns / 1ps

module ebrld_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_valid_count,
    input logic       i_last,
    input logic       i_trunc
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken while a word is in work");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_valid_count <= 4'd8))
        else $error("valid_count above lane count");

    a_full_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> (i_valid_count == 4'd8))
        else $error("partial word before the final one");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_trunc) |-> i_last)
        else $error("truncated flag on a non-final word");

    a_run_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !i_last) |=> i_out_valid)
        else $error("run output stalled mid-run");

endmodule

bind escape_byte_run_length_decoder ebrld_chk u_ebrld_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_valid_count (o_out.valid_count),
    .i_last        (o_out.last_of_input),
    .i_trunc       (o_out.truncated)
);

// ===== test/tb_escape_byte_run_length_decoder.sv =====
`timescale 1ns / 1ps

module tb_escape_byte_run_length_decoder;
    import ebrld_pkg::*;

    localparam longint unsigned TOTAL_LIM = (64'd1 << TOTAL_WIDTH) - 64'd1;
    localparam int RANDOM_STOP = 212;

    typedef struct packed {
        logic [7:0][7:0] lane;
        logic [3:0]      count;
        logic            last;
        logic [23:0]     total;
        logic            trunc;
    } dec_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ebrld_in_if  in_if ();
    ebrld_out_if out_if ();

    escape_byte_run_length_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    dec_word_t       decoded_q [$];
    t_phase          dec_phase;
    logic [7:0]      dec_run;
    longint unsigned blk_total;
    int              err_cnt;
    int              items_sent;
    int              burst_left;
    logic [15:0]     stall_pat;
    int              mode_left;
    dec_word_t       want_w;
    logic [7:0][7:0] got_lanes;

    function automatic void decode_word(input logic [7:0] b, input logic eob);
        int unsigned emit;
        int unsigned done;
        int unsigned chunk;
        int          k;
        logic [7:0]  val;
        logic        trunc;
        dec_word_t   w;
        emit = 0;
        done = 0;
        val  = 8'h00;
        case (dec_phase)
            PH_COUNT: begin
                if (b < SHORT_LIMIT) begin
                    emit      = b + 1;
                    val       = ESC_BYTE;
                    dec_phase = PH_LIT;
                end else begin
                    dec_run   = b;
                    dec_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                emit      = dec_run + 1;
                val       = b;
                dec_phase = PH_LIT;
                dec_run   = 8'h00;
            end
            default: begin
                if (b == ESC_BYTE) begin
                    dec_phase = PH_COUNT;
                end else begin
                    emit      = 1;
                    val       = b;
                    dec_phase = PH_LIT;
                end
            end
        endcase
        trunc = eob && (dec_phase != PH_LIT);
        do begin
            chunk = emit - done;
            if (chunk > LANE_CNT) chunk = LANE_CNT;
            w = '0;
            for (k = 0; k < 8; k++) begin
                if (k < chunk) w.lane[k] = val;
            end
            done += chunk;
            if (blk_total + chunk > TOTAL_LIM) blk_total = TOTAL_LIM;
            else blk_total += chunk;
            w.count = chunk[3:0];
            w.last  = (done >= emit);
            w.total = blk_total[23:0];
            w.trunc = (done >= emit) && trunc;
            decoded_q.push_back(w);
        end while (done < emit);
        if (eob) begin
            dec_phase = PH_LIT;
            dec_run   = 8'h00;
            blk_total = 0;
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eob);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.end_of_block <= eob;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        decode_word(b, eob);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_block(input logic [7:0] blk_q [$]);
        int k;
        for (k = 0; k < blk_q.size(); k++) send_word(blk_q[k], k == blk_q.size() - 1);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_literals();
        send_word(8'h00, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'hFE, 1'b1);
    endtask

    task automatic test_short_escapes();
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h02, 1'b1);
    endtask

    task automatic test_runs();
        send_word(ESC_BYTE, 1'b0);
        send_word(SHORT_LIMIT, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'h3C, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h11, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(ESC_BYTE, 1'b1);
    endtask

    task automatic test_truncation();
        send_word(ESC_BYTE, 1'b1);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h05, 1'b1);
        send_word(8'h7F, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h27, 1'b0);
        send_word(8'h81, 1'b0);
        wait_drained();
        send_word(8'h12, 1'b1);
    endtask

    task automatic test_random_stream();
        logic [7:0] blk_q [$];
        int         kind;
        int         cnt;
        while (items_sent < RANDOM_STOP) begin
            blk_q.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) blk_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 5) begin
                        blk_q.push_back(8'($urandom_range(0, 254)));
                    end else if (kind < 7) begin
                        blk_q.push_back(ESC_BYTE);
                        blk_q.push_back(8'($urandom_range(0, 2)));
                    end else begin
                        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255)
                                                          : $urandom_range(3, 24);
                        blk_q.push_back(ESC_BYTE);
                        blk_q.push_back(8'(cnt));
                        blk_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
                if ($urandom_range(0, 7) == 0) begin
                    blk_q.push_back(ESC_BYTE);
                    if ($urandom_range(0, 1) == 1) blk_q.push_back(8'($urandom_range(3, 255)));
                end
            end
            send_block(blk_q);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
    endtask

    initial begin
        out_if.ready <= 1'b0;
        stall_pat = 16'hFFFF;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
                    2: stall_pat = 16'h0101;
                    default: stall_pat = 16'hEEEE;
                endcase
            end
            out_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            mode_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                err_cnt++;
                $error("unexpected word: count %0d, last %0b", out_if.valid_count,
                       out_if.last_of_input);
            end else begin
                want_w    = decoded_q.pop_front();
                got_lanes = {out_if.lane7, out_if.lane6, out_if.lane5, out_if.lane4,
                             out_if.lane3, out_if.lane2, out_if.lane1, out_if.lane0};
                for (int k = 0; k < 8; k++) begin
                    if (got_lanes[k] !== want_w.lane[k]) begin
                        err_cnt++;
                        $error("lane%0d: expected %02h, actual %02h", k, want_w.lane[k],
                               got_lanes[k]);
                    end
                end
                if (out_if.valid_count !== want_w.count) begin
                    err_cnt++;
                    $error("valid_count: expected %0d, actual %0d", want_w.count,
                           out_if.valid_count);
                end
                if (out_if.last_of_input !== want_w.last) begin
                    err_cnt++;
                    $error("last_of_input: expected %0b, actual %0b", want_w.last,
                           out_if.last_of_input);
                end
                if (out_if.total_length !== want_w.total) begin
                    err_cnt++;
                    $error("total_length: expected %0d, actual %0d", want_w.total,
                           out_if.total_length);
                end
                if (out_if.truncated !== want_w.trunc) begin
                    err_cnt++;
                    $error("truncated: expected %0b, actual %0b", want_w.trunc,
                           out_if.truncated);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        err_cnt    = 0;
        items_sent = 0;
        burst_left = 0;
        dec_phase  = PH_LIT;
        dec_run    = 8'h00;
        blk_total  = 0;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= 8'h00;
        in_if.end_of_block <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_literals();
        test_short_escapes();
        test_runs();
        test_truncation();
        test_drain_pause();
        test_random_stream();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
